>>> design/kscd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kscd_pkg: keyboard scan code decoder shared definitions
// Scan codes, operation classes, action codes and the set-1 character tables.
// ----------------------------------------------------------------------------
package kscd_pkg;

  localparam int DEFAULT_CMD_QUEUE_DEPTH = 32;
  localparam int DEFAULT_LINE_COLUMNS    = 15;

  localparam logic [7:0] LED_COMMAND    = 8'hED;
  localparam logic [7:0] KEY_BACKSPACE  = 8'h0E;
  localparam logic [7:0] KEY_TAB        = 8'h0F;
  localparam logic [7:0] KEY_ENTER      = 8'h1C;
  localparam logic [7:0] KEY_LSHIFT_ON  = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT_ON  = 8'h36;
  localparam logic [7:0] KEY_LSHIFT_OFF = 8'hAA;
  localparam logic [7:0] KEY_RSHIFT_OFF = 8'hB6;
  localparam logic [7:0] KEY_CAPS       = 8'h3A;
  localparam logic [7:0] KEY_NUM        = 8'h45;
  localparam logic [7:0] KEY_SCROLL     = 8'h46;
  localparam logic [7:0] REPLY_ACK      = 8'hFA;
  localparam logic [7:0] REPLY_RESEND   = 8'hFE;

  localparam logic [2:0] LED_SCROLL_BIT = 3'b001;
  localparam logic [2:0] LED_NUM_BIT    = 3'b010;
  localparam logic [2:0] LED_CAPS_BIT   = 3'b100;

  typedef enum logic [3:0] {
    OP_OTHER,
    OP_BACKSPACE,
    OP_ENTER,
    OP_TAB,
    OP_LSHIFT_ON,
    OP_RSHIFT_ON,
    OP_LSHIFT_OFF,
    OP_RSHIFT_OFF,
    OP_CAPS,
    OP_NUM,
    OP_SCROLL,
    OP_ACK,
    OP_RESEND
  } op_kind_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WIN_CHAR,
    ACT_WIN_BS,
    ACT_CON_CHAR,
    ACT_CON_BS,
    ACT_CON_ENTER,
    ACT_FOCUS_CON,
    ACT_FOCUS_WIN
  } action_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RESEND,
    SRC_IMM,
    SRC_RAM
  } send_src_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [6:0] plain_char;
    logic [6:0] shift_char;
  } op_t;

  function automatic logic [6:0] plain_char_lookup(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h02: c = 7'h31;
      7'h03: c = 7'h32;
      7'h04: c = 7'h33;
      7'h05: c = 7'h34;
      7'h06: c = 7'h35;
      7'h07: c = 7'h36;
      7'h08: c = 7'h37;
      7'h09: c = 7'h38;
      7'h0A: c = 7'h39;
      7'h0B: c = 7'h30;
      7'h0C: c = 7'h2D;
      7'h0D: c = 7'h5E;
      7'h10: c = 7'h51;
      7'h11: c = 7'h57;
      7'h12: c = 7'h45;
      7'h13: c = 7'h52;
      7'h14: c = 7'h54;
      7'h15: c = 7'h59;
      7'h16: c = 7'h55;
      7'h17: c = 7'h49;
      7'h18: c = 7'h4F;
      7'h19: c = 7'h50;
      7'h1A: c = 7'h40;
      7'h1B: c = 7'h5B;
      7'h1E: c = 7'h41;
      7'h1F: c = 7'h53;
      7'h20: c = 7'h44;
      7'h21: c = 7'h46;
      7'h22: c = 7'h47;
      7'h23: c = 7'h48;
      7'h24: c = 7'h4A;
      7'h25: c = 7'h4B;
      7'h26: c = 7'h4C;
      7'h27: c = 7'h3B;
      7'h28: c = 7'h3A;
      7'h2B: c = 7'h5D;
      7'h2C: c = 7'h5A;
      7'h2D: c = 7'h58;
      7'h2E: c = 7'h43;
      7'h2F: c = 7'h56;
      7'h30: c = 7'h42;
      7'h31: c = 7'h4E;
      7'h32: c = 7'h4D;
      7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;
      7'h35: c = 7'h2F;
      7'h37: c = 7'h2A;
      7'h39: c = 7'h20;
      7'h47: c = 7'h37;
      7'h48: c = 7'h38;
      7'h49: c = 7'h39;
      7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34;
      7'h4C: c = 7'h35;
      7'h4D: c = 7'h36;
      7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31;
      7'h50: c = 7'h32;
      7'h51: c = 7'h33;
      7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shift_char_lookup(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h02: c = 7'h21;
      7'h03: c = 7'h22;
      7'h04: c = 7'h23;
      7'h05: c = 7'h24;
      7'h06: c = 7'h25;
      7'h07: c = 7'h26;
      7'h08: c = 7'h27;
      7'h09: c = 7'h28;
      7'h0A: c = 7'h29;
      7'h0B: c = 7'h7E;
      7'h0C: c = 7'h3D;
      7'h0D: c = 7'h7E;
      7'h1A: c = 7'h60;
      7'h1B: c = 7'h7B;
      7'h27: c = 7'h2B;
      7'h28: c = 7'h2A;
      7'h2B: c = 7'h7D;
      7'h33: c = 7'h3C;
      7'h34: c = 7'h3E;
      7'h35: c = 7'h3F;
      7'h73: c = 7'h5F;
      7'h7D: c = 7'h7C;
      default: c = plain_char_lookup(code);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/kscd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kscd_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/kscd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kscd_front: scan code classifier and operation queue
// Sorts each byte into an operation class, looks up both character tables
// and holds the result in a two-entry queue for the execute side.
// ----------------------------------------------------------------------------
module kscd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             code_valid_i,
  output logic                  code_ready_o,
  input  wire logic [7:0]       code_i,
  output logic                  op_valid_o,
  input  wire logic             op_ready_i,
  output kscd_pkg::op_t         op_o
);
  import kscd_pkg::*;

  op_t        op_new;
  op_t        entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    op_new = '0;
    unique case (code_i)
      KEY_BACKSPACE:  op_new.kind = OP_BACKSPACE;
      KEY_ENTER:      op_new.kind = OP_ENTER;
      KEY_TAB:        op_new.kind = OP_TAB;
      KEY_LSHIFT_ON:  op_new.kind = OP_LSHIFT_ON;
      KEY_RSHIFT_ON:  op_new.kind = OP_RSHIFT_ON;
      KEY_LSHIFT_OFF: op_new.kind = OP_LSHIFT_OFF;
      KEY_RSHIFT_OFF: op_new.kind = OP_RSHIFT_OFF;
      KEY_CAPS:       op_new.kind = OP_CAPS;
      KEY_NUM:        op_new.kind = OP_NUM;
      KEY_SCROLL:     op_new.kind = OP_SCROLL;
      REPLY_ACK:      op_new.kind = OP_ACK;
      REPLY_RESEND:   op_new.kind = OP_RESEND;
      default:        op_new.kind = OP_OTHER;
    endcase
    // release codes have no table entry
    if (!code_i[7]) begin
      op_new.plain_char = plain_char_lookup(code_i[6:0]);
      op_new.shift_char = shift_char_lookup(code_i[6:0]);
    end
  end

  assign code_ready_o = (cnt_q != 2'd2);
  assign op_valid_o   = (cnt_q != 2'd0);
  assign op_o         = entry_q[rd_q];
  assign push         = code_valid_i && code_ready_o;
  assign pop          = op_valid_o && op_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= op_new;
    end
  end

endmodule
`default_nettype wire

>>> design/kscd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kscd_back: keyboard state and LED command queue
// One operation per cycle unless stalled: character translation, window line,
// focus, shift and lock state, command byte queue and result register.
// ----------------------------------------------------------------------------
module kscd_back #(
  parameter int CMD_QUEUE_DEPTH = kscd_pkg::DEFAULT_CMD_QUEUE_DEPTH,
  parameter int LINE_COLUMNS    = kscd_pkg::DEFAULT_LINE_COLUMNS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             op_valid_i,
  output logic                  op_ready_o,
  input  wire kscd_pkg::op_t    op_i,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_leds_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic [2:0]            action_o,
  output logic [6:0]            char_code_o,
  output logic [3:0]            window_col_o,
  output logic                  focus_console_o,
  output logic [2:0]            lock_leds_o,
  output logic                  send_valid_o,
  output logic [7:0]            send_byte_o
);
  import kscd_pkg::*;

  localparam int BankDepth = (CMD_QUEUE_DEPTH + 1) / 2;
  localparam int Slots     = 2 * BankDepth;
  localparam int PtrW      = $clog2(Slots);
  localparam int RowW      = PtrW - 1;
  localparam int CntW      = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int ColW      = $clog2(LINE_COLUMNS + 1);

  typedef struct packed {
    action_e    action;
    logic [6:0] char_code;
    logic [3:0] col;
    logic       focus;
    logic [2:0] leds;
    send_src_e  src;
    logic [7:0] imm;
    logic       bank;
  } res_t;

  function automatic logic [PtrW-1:0] slot_inc(input logic [PtrW-1:0] s);
    logic [PtrW-1:0] r;
    if (s == PtrW'(Slots - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  logic [1:0]      shift_q, shift_d;
  logic [2:0]      led_q, led_d;
  logic            focus_q, focus_d;
  logic [ColW-1:0] col_q, col_d;
  logic            ack_q, ack_d;
  logic            started_q;
  logic [1:0]      pre_cnt_q, pre_cnt_d;
  logic [2:0]      pre_led_q;
  logic [CntW-1:0] ram_cnt_q, ram_cnt_d;
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic            b_valid_q;
  res_t            b_q, b_d;
  logic [7:0]      await_q;

  logic            exec;
  logic            shifted;
  logic [6:0]      ch;
  logic            ack_mid;
  logic            lock;
  logic [CntW-1:0] total;
  logic [CntW:0]   total_p1;
  logic            push1, push2;
  logic [CntW-1:0] ram_after;
  logic            pop;
  logic [PtrW-1:0] w1, w2, w3;
  logic [ColW+3:0] col_ext;
  logic            use1_b0, use1_b1;
  logic            we0, we1, re0, re1;
  logic [RowW-1:0] waddr0, waddr1;
  logic [7:0]      wdata0, wdata1;
  logic [7:0]      rdata0, rdata1;
  logic            fire;

  assign op_ready_o = !b_valid_q || res_ready_i;
  assign exec       = op_valid_i && op_ready_o;
  assign fire       = b_valid_q && res_ready_i;

  always_comb begin
    shift_d   = shift_q;
    led_d     = led_q;
    focus_d   = focus_q;
    col_d     = col_q;
    ack_mid   = ack_q;
    lock      = 1'b0;
    b_d       = '0;
    b_d.action = ACT_NONE;
    b_d.src    = SRC_NONE;

    shifted = (shift_q != 2'b00);
    ch      = shifted ? op_i.shift_char : op_i.plain_char;
    if (ch >= 7'h41 && ch <= 7'h5A && led_q[2] == shifted) begin
      ch = ch | 7'h20;
    end

    if (ch != 7'h00) begin
      if (!focus_q) begin
        if (col_q < ColW'(LINE_COLUMNS)) begin
          col_d        = col_q + 1'b1;
          b_d.action    = ACT_WIN_CHAR;
          b_d.char_code = ch;
        end
      end else begin
        b_d.action    = ACT_CON_CHAR;
        b_d.char_code = ch;
      end
    end

    case (op_i.kind)
      OP_BACKSPACE: begin
        if (!focus_q) begin
          if (col_q != '0) begin
            col_d     = col_q - 1'b1;
            b_d.action = ACT_WIN_BS;
          end
        end else begin
          b_d.action = ACT_CON_BS;
        end
      end
      OP_ENTER: begin
        if (focus_q) begin
          b_d.action = ACT_CON_ENTER;
        end
      end
      OP_TAB: begin
        focus_d   = !focus_q;
        b_d.action = focus_d ? ACT_FOCUS_CON : ACT_FOCUS_WIN;
      end
      OP_LSHIFT_ON:  shift_d[0] = 1'b1;
      OP_RSHIFT_ON:  shift_d[1] = 1'b1;
      OP_LSHIFT_OFF: shift_d[0] = 1'b0;
      OP_RSHIFT_OFF: shift_d[1] = 1'b0;
      OP_CAPS: begin
        led_d = led_q ^ LED_CAPS_BIT;
        lock  = 1'b1;
      end
      OP_NUM: begin
        led_d = led_q ^ LED_NUM_BIT;
        lock  = 1'b1;
      end
      OP_SCROLL: begin
        led_d = led_q ^ LED_SCROLL_BIT;
        lock  = 1'b1;
      end
      OP_ACK: ack_mid = 1'b0;
      OP_RESEND: begin
        if (ack_q) begin
          b_d.src = SRC_RESEND;
        end
      end
      default: ;
    endcase

    // command byte queue: preloaded reset bytes ahead of the ram contents
    total     = CntW'(pre_cnt_q) + ram_cnt_q;
    total_p1  = {1'b0, total} + (CntW + 1)'(1);
    push1     = lock && (total < CntW'(CMD_QUEUE_DEPTH));
    push2     = lock && (total_p1 < (CntW + 1)'(CMD_QUEUE_DEPTH));
    ram_after = ram_cnt_q + CntW'(push1) + CntW'(push2);
    pop       = !ack_mid && ((pre_cnt_q != 2'd0) || (ram_after != '0));

    w1   = wr_q;
    w2   = slot_inc(w1);
    w3   = slot_inc(w2);
    wr_d = push2 ? w3 : (push1 ? w2 : w1);

    ack_d     = ack_mid;
    pre_cnt_d = pre_cnt_q;
    ram_cnt_d = ram_after;
    rd_d      = rd_q;
    if (pop) begin
      ack_d = 1'b1;
      if (pre_cnt_q != 2'd0) begin
        pre_cnt_d = pre_cnt_q - 2'd1;
        b_d.src   = SRC_IMM;
        b_d.imm   = (pre_cnt_q == 2'd2) ? LED_COMMAND : {5'b0, pre_led_q};
      end else begin
        ram_cnt_d = ram_after - 1'b1;
        rd_d      = slot_inc(rd_q);
        if (ram_cnt_q == '0) begin
          // head is the command byte written in this same cycle
          b_d.src = SRC_IMM;
          b_d.imm = LED_COMMAND;
        end else begin
          b_d.src = SRC_RAM;
        end
      end
    end

    col_ext   = {4'b0, col_d};
    b_d.col   = col_ext[3:0];
    b_d.focus = focus_d;
    b_d.leds  = led_d;
    b_d.bank  = rd_q[0];
  end

  always_comb begin
    use1_b0 = push1 && !w1[0];
    use1_b1 = push1 && w1[0];
    we0     = exec && (use1_b0 || (push2 && !w2[0]));
    we1     = exec && (use1_b1 || (push2 && w2[0]));
    waddr0  = use1_b0 ? w1[PtrW-1:1] : w2[PtrW-1:1];
    waddr1  = use1_b1 ? w1[PtrW-1:1] : w2[PtrW-1:1];
    wdata0  = use1_b0 ? LED_COMMAND : {5'b0, led_d};
    wdata1  = use1_b1 ? LED_COMMAND : {5'b0, led_d};
    re0     = exec && pop && (b_d.src == SRC_RAM) && !rd_q[0];
    re1     = exec && pop && (b_d.src == SRC_RAM) && rd_q[0];
  end

  kscd_ram #(
    .WIDTH(8),
    .DEPTH(BankDepth)
  ) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (we0),
    .waddr_i(waddr0),
    .wdata_i(wdata0),
    .re_i   (re0),
    .raddr_i(rd_q[PtrW-1:1]),
    .rdata_o(rdata0)
  );

  kscd_ram #(
    .WIDTH(8),
    .DEPTH(BankDepth)
  ) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(waddr1),
    .wdata_i(wdata1),
    .re_i   (re1),
    .raddr_i(rd_q[PtrW-1:1]),
    .rdata_o(rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= 2'b00;
      led_q     <= 3'b000;
      focus_q   <= 1'b0;
      col_q     <= '0;
      ack_q     <= 1'b0;
      started_q <= 1'b0;
      pre_cnt_q <= 2'd2;
      pre_led_q <= 3'b000;
      ram_cnt_q <= '0;
      wr_q      <= '0;
      rd_q      <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        shift_q   <= shift_d;
        led_q     <= led_d;
        focus_q   <= focus_d;
        col_q     <= col_d;
        ack_q     <= ack_d;
        started_q <= 1'b1;
        pre_cnt_q <= pre_cnt_d;
        ram_cnt_q <= ram_cnt_d;
        wr_q      <= wr_d;
        rd_q      <= rd_d;
        b_valid_q <= 1'b1;
      end else begin
        if (cfg_we_i && !started_q) begin
          led_q     <= cfg_leds_i;
          pre_led_q <= cfg_leds_i;
        end
        if (fire) begin
          b_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      b_q <= b_d;
    end
    if (fire && (b_q.src == SRC_IMM || b_q.src == SRC_RAM)) begin
      await_q <= send_byte_o;
    end
  end

  always_comb begin
    unique case (b_q.src)
      SRC_NONE:   send_byte_o = 8'h00;
      SRC_RESEND: send_byte_o = await_q;
      SRC_IMM:    send_byte_o = b_q.imm;
      SRC_RAM:    send_byte_o = b_q.bank ? rdata1 : rdata0;
      default:    send_byte_o = 8'h00;
    endcase
  end

  assign res_valid_o     = b_valid_q;
  assign action_o        = b_q.action;
  assign char_code_o     = b_q.char_code;
  assign window_col_o    = b_q.col;
  assign focus_console_o = b_q.focus;
  assign lock_leds_o     = b_q.leds;
  assign send_valid_o    = (b_q.src != SRC_NONE);

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= CntW'(CMD_QUEUE_DEPTH))
    else $error("command queue holds more bytes than its depth");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q && !ack_q |-> total == '0)
    else $error("queued byte left unsent with no byte awaiting ack");

  a_preload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_cnt_q != 2'd3)
    else $error("preload count out of range");

  a_preload_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_cnt_q != $past(pre_cnt_q) |-> pre_cnt_q == $past(pre_cnt_q) - 2'd1)
    else $error("preload count moved other than by one pop");
`endif

endmodule
`default_nettype wire

>>> design/keyboard_scan_code_decoder.sv
// Path: a scan code is held in the operation queue, then executed into the
// result register, where its result waits to be accepted.
// Throughput: one scan code per cycle while results are accepted;
// the two-entry operation queue and the result register keep both sides apart.
// Reset: keyboard state cleared, LED bits and queue preload follow the
// initial_leds register until the first scan code; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_scan_code_decoder: set-1 scan code decoder with LED command queue
// Translates keyboard bytes to key actions and sends queued LED commands.
// ----------------------------------------------------------------------------
module keyboard_scan_code_decoder #(
  parameter int CMD_QUEUE_DEPTH = kscd_pkg::DEFAULT_CMD_QUEUE_DEPTH,
  parameter int LINE_COLUMNS    = kscd_pkg::DEFAULT_LINE_COLUMNS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       scan_code_valid_i,
  output logic            scan_code_ready_o,
  input  wire logic [7:0] scan_code_i,
  input  wire logic       initial_leds_we_i,
  input  wire logic [2:0] initial_leds_i,
  output logic            result_valid_o,
  input  wire logic       result_ready_i,
  output logic [2:0]      action_o,
  output logic [6:0]      char_code_o,
  output logic [3:0]      window_col_o,
  output logic            focus_console_o,
  output logic [2:0]      lock_leds_o,
  output logic            send_valid_o,
  output logic [7:0]      send_byte_o
);
  import kscd_pkg::*;

  logic op_valid;
  logic op_ready;
  op_t  op;

  kscd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_valid_i(scan_code_valid_i),
    .code_ready_o(scan_code_ready_o),
    .code_i      (scan_code_i),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_o        (op)
  );

  kscd_back #(
    .CMD_QUEUE_DEPTH(CMD_QUEUE_DEPTH),
    .LINE_COLUMNS   (LINE_COLUMNS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_ready_o     (op_ready),
    .op_i           (op),
    .cfg_we_i       (initial_leds_we_i),
    .cfg_leds_i     (initial_leds_i),
    .res_valid_o    (result_valid_o),
    .res_ready_i    (result_ready_i),
    .action_o       (action_o),
    .char_code_o    (char_code_o),
    .window_col_o   (window_col_o),
    .focus_console_o(focus_console_o),
    .lock_leds_o    (lock_leds_o),
    .send_valid_o   (send_valid_o),
    .send_byte_o    (send_byte_o)
  );

endmodule
`default_nettype wire

>>> bench/tb_keyboard_scan_code_decoder.sv
// ----------------------------------------------------------------------------
// tb_keyboard_scan_code_decoder: self-checking bench for the scan code decoder
// Drives scan code requests and initial LED writes, predicts every result from
// its own model of the decoder state and LED command queue, and checks each
// result field against the oldest prediction under random handshake idling.
// ----------------------------------------------------------------------------
module tb_keyboard_scan_code_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import kscd_pkg::*;

  localparam int CMD_DEPTH      = DEFAULT_CMD_QUEUE_DEPTH;
  localparam int FIFO_AW        = $clog2(CMD_DEPTH);
  localparam int LINE_COLS      = DEFAULT_LINE_COLUMNS;
  localparam int STALL_LIMIT    = 10000;
  localparam int MAX_REPORTS    = 30;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    action_e    action;
    logic [6:0] char_code;
    logic [3:0] window_col;
    logic       focus_console;
    logic [2:0] lock_leds;
    logic       send_valid;
    logic [7:0] send_byte;
  } key_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       scan_code_valid_i;
  logic       scan_code_ready_o;
  logic [7:0] scan_code_i;
  logic       initial_leds_we_i;
  logic [2:0] initial_leds_i;
  logic       result_valid_o;
  logic       result_ready_i = 1'b0;
  logic [2:0] action_o;
  logic [6:0] char_code_o;
  logic [3:0] window_col_o;
  logic       focus_console_o;
  logic [2:0] lock_leds_o;
  logic       send_valid_o;
  logic [7:0] send_byte_o;

  keyboard_scan_code_decoder #(
    .CMD_QUEUE_DEPTH(CMD_DEPTH),
    .LINE_COLUMNS   (LINE_COLS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .scan_code_valid_i(scan_code_valid_i),
    .scan_code_ready_o(scan_code_ready_o),
    .scan_code_i      (scan_code_i),
    .initial_leds_we_i(initial_leds_we_i),
    .initial_leds_i   (initial_leds_i),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .action_o         (action_o),
    .char_code_o      (char_code_o),
    .window_col_o     (window_col_o),
    .focus_console_o  (focus_console_o),
    .lock_leds_o      (lock_leds_o),
    .send_valid_o     (send_valid_o),
    .send_byte_o      (send_byte_o)
  );

  // decoder model state
  logic [6:0]  plain_tab [128];
  logic [6:0]  shift_tab [128];
  logic [1:0]  shift_q;
  logic [2:0]  leds_q;
  logic        focus_q;
  int          line_col;
  logic [7:0]  cmd_fifo [CMD_DEPTH];
  int          fifo_head;
  int          fifo_count;
  logic [7:0]  pending_byte;
  bit          pending_ack;
  bit          seen_item;

  key_result_t key_results_q[$];
  int          error_count = 0;
  int          stall_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic put_chars(input bit to_shift, input logic [6:0] first, input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (to_shift) begin
        shift_tab[first + 7'(i)] = 7'(s[i]);
      end else begin
        plain_tab[first + 7'(i)] = 7'(s[i]);
      end
    end
  endtask

  function automatic void fifo_push(input logic [7:0] b);
    if (fifo_count < CMD_DEPTH) begin
      cmd_fifo[FIFO_AW'((fifo_head + fifo_count) % CMD_DEPTH)] = b;
      fifo_count++;
    end
  endfunction

  function automatic void toggle_led(input logic [2:0] mask);
    leds_q = leds_q ^ mask;
    fifo_push(LED_COMMAND);
    fifo_push({5'b0, leds_q});
  endfunction

  function automatic void apply_initial_leds(input logic [2:0] v);
    if (!seen_item) begin
      leds_q = v;
      cmd_fifo[1] = {5'b0, v};
    end
  endfunction

  function automatic key_result_t decode_key(input logic [7:0] code);
    key_result_t r;
    logic [6:0]  c;
    logic        shifted;
    r = '0;
    r.action = ACT_NONE;
    shifted = (shift_q != 2'b00);
    seen_item = 1'b1;
    c = 7'h00;
    if (!code[7]) begin
      c = shifted ? shift_tab[code[6:0]] : plain_tab[code[6:0]];
    end
    if (c >= 7'h41 && c <= 7'h5A && leds_q[2] == shifted) begin
      c = c + 7'h20;
    end
    if (c != 7'h00) begin
      if (!focus_q) begin
        if (line_col < LINE_COLS) begin
          line_col++;
          r.action = ACT_WIN_CHAR;
          r.char_code = c;
        end
      end else begin
        r.action = ACT_CON_CHAR;
        r.char_code = c;
      end
    end
    case (code)
      KEY_BACKSPACE: begin
        if (!focus_q) begin
          if (line_col > 0) begin
            line_col--;
            r.action = ACT_WIN_BS;
          end
        end else begin
          r.action = ACT_CON_BS;
        end
      end
      KEY_ENTER: begin
        if (focus_q) r.action = ACT_CON_ENTER;
      end
      KEY_TAB: begin
        focus_q = ~focus_q;
        r.action = focus_q ? ACT_FOCUS_CON : ACT_FOCUS_WIN;
      end
      KEY_LSHIFT_ON:  shift_q[0] = 1'b1;
      KEY_RSHIFT_ON:  shift_q[1] = 1'b1;
      KEY_LSHIFT_OFF: shift_q[0] = 1'b0;
      KEY_RSHIFT_OFF: shift_q[1] = 1'b0;
      KEY_CAPS:       toggle_led(LED_CAPS_BIT);
      KEY_NUM:        toggle_led(LED_NUM_BIT);
      KEY_SCROLL:     toggle_led(LED_SCROLL_BIT);
      REPLY_ACK:      pending_ack = 1'b0;
      REPLY_RESEND: begin
        if (pending_ack) begin
          r.send_valid = 1'b1;
          r.send_byte = pending_byte;
        end
      end
      default: ;
    endcase
    if (!pending_ack && fifo_count > 0) begin
      pending_byte = cmd_fifo[FIFO_AW'(fifo_head)];
      fifo_head = (fifo_head + 1) % CMD_DEPTH;
      fifo_count--;
      pending_ack = 1'b1;
      r.send_valid = 1'b1;
      r.send_byte = pending_byte;
    end
    r.window_col = line_col[3:0];
    r.focus_console = focus_q;
    r.lock_leds = leds_q;
    return r;
  endfunction

  // one scan code request, called and returning at a falling edge
  task automatic send_scan_code(input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      scan_code_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    scan_code_valid_i <= 1'b1;
    scan_code_i <= code;
    do @(posedge clk_i); while (!scan_code_ready_o);
    key_results_q.push_back(decode_key(code));
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    scan_code_valid_i <= 1'b0;
    while (key_results_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_initial_leds(input logic [2:0] v);
    initial_leds_we_i <= 1'b1;
    initial_leds_i <= v;
    @(posedge clk_i);
    apply_initial_leds(v);
    @(negedge clk_i);
    initial_leds_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_scan_code();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 40) begin
      do c = 8'($urandom_range(127)); while (plain_tab[c[6:0]] == 7'h00);
    end else if (pick < 52) begin
      c = KEY_BACKSPACE;
    end else if (pick < 56) begin
      c = KEY_ENTER;
    end else if (pick < 61) begin
      c = KEY_TAB;
    end else if (pick < 69) begin
      case ($urandom_range(3))
        0:       c = KEY_LSHIFT_ON;
        1:       c = KEY_RSHIFT_ON;
        2:       c = KEY_LSHIFT_OFF;
        default: c = KEY_RSHIFT_OFF;
      endcase
    end else if (pick < 75) begin
      case ($urandom_range(2))
        0:       c = KEY_CAPS;
        1:       c = KEY_NUM;
        default: c = KEY_SCROLL;
      endcase
    end else if (pick < 87) begin
      c = REPLY_ACK;
    end else if (pick < 90) begin
      c = REPLY_RESEND;
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("tb: mismatch %s expected 0x%0h got 0x%0h at %0t", what, want, got, $time);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (key_results_q.size() == 0) begin
        report_mismatch("unexpected result action", 0, 32'(action_o));
      end else begin
        want = key_results_q.pop_front();
        if (action_o !== want.action)
          report_mismatch("action", 32'(want.action), 32'(action_o));
        if (char_code_o !== want.char_code)
          report_mismatch("char_code", 32'(want.char_code), 32'(char_code_o));
        if (window_col_o !== want.window_col)
          report_mismatch("window_col", 32'(want.window_col), 32'(window_col_o));
        if (focus_console_o !== want.focus_console)
          report_mismatch("focus_console", 32'(want.focus_console), 32'(focus_console_o));
        if (lock_leds_o !== want.lock_leds)
          report_mismatch("lock_leds", 32'(want.lock_leds), 32'(lock_leds_o));
        if (send_valid_o !== want.send_valid)
          report_mismatch("send_valid", 32'(want.send_valid), 32'(send_valid_o));
        if (send_byte_o !== want.send_byte)
          report_mismatch("send_byte", 32'(want.send_byte), 32'(send_byte_o));
      end
    end
  end

  // result side ready, with hold-off counted here
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_OFF_CYCLES - 1;
      result_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      result_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((scan_code_valid_i && scan_code_ready_o) || (result_valid_o && result_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_leds_before_start();
    write_initial_leds(3'd7);
    write_initial_leds(3'd0);
    write_initial_leds(3'd5);
  endtask

  task automatic test_directed_keys();
    logic [7:0] codes [$];
    codes = '{8'h00, REPLY_RESEND, REPLY_ACK, REPLY_ACK, REPLY_RESEND,
              KEY_BACKSPACE, KEY_ENTER, 8'h1E, KEY_LSHIFT_ON, 8'h1E, 8'h02,
              8'h73, 8'h7D, KEY_LSHIFT_OFF, KEY_RSHIFT_ON, 8'h0B, KEY_RSHIFT_OFF,
              KEY_CAPS, KEY_NUM, KEY_SCROLL, KEY_TAB, 8'h7F, KEY_BACKSPACE,
              KEY_ENTER, KEY_TAB, 8'hFF};
    foreach (codes[i]) send_scan_code(codes[i]);
  endtask

  task automatic test_window_line_full();
    repeat (LINE_COLS + 2) send_scan_code(8'h1E);
    repeat (LINE_COLS + 2) send_scan_code(KEY_BACKSPACE);
  endtask

  task automatic test_command_queue_overflow();
    repeat (20) send_scan_code(KEY_NUM);
    repeat (CMD_DEPTH + 3) send_scan_code(REPLY_ACK);
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) send_scan_code(random_scan_code());
  endtask

  task automatic test_result_backpressure();
    scan_code_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_req++;
    @(negedge clk_i);
    test_random_traffic(40);
    wait_results_drained();
    test_random_traffic(40);
  endtask

  initial begin
    rst_ni = 1'b0;
    scan_code_valid_i = 1'b0;
    scan_code_i = 8'h00;
    initial_leds_we_i = 1'b0;
    initial_leds_i = 3'd0;
    send_idle_pct = 12;
    recv_idle_pct = 76;
    foreach (plain_tab[i]) plain_tab[i] = 7'h00;
    put_chars(1'b0, 7'h02, "1234567890-^");
    put_chars(1'b0, 7'h10, "QWERTYUIOP@[");
    put_chars(1'b0, 7'h1E, "ASDFGHJKL;:");
    put_chars(1'b0, 7'h2B, "]ZXCVBNM,./");
    put_chars(1'b0, 7'h37, "*");
    put_chars(1'b0, 7'h39, " ");
    put_chars(1'b0, 7'h47, "789-456+1230.");
    foreach (shift_tab[i]) shift_tab[i] = plain_tab[i];
    put_chars(1'b1, 7'h02, "!\"#$%&'()~=~");
    put_chars(1'b1, 7'h1A, "`{");
    put_chars(1'b1, 7'h27, "+*");
    put_chars(1'b1, 7'h2B, "}");
    put_chars(1'b1, 7'h33, "<>?");
    put_chars(1'b1, 7'h73, "_");
    put_chars(1'b1, 7'h7D, "|");
    shift_q = 2'b00;
    leds_q = 3'd0;
    focus_q = 1'b0;
    line_col = 0;
    foreach (cmd_fifo[i]) cmd_fifo[i] = 8'h00;
    cmd_fifo[0] = LED_COMMAND;
    fifo_head = 0;
    fifo_count = 2;
    pending_byte = 8'h00;
    pending_ack = 1'b0;
    seen_item = 1'b0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_leds_before_start();
    test_directed_keys();
    test_window_line_full();
    test_command_queue_overflow();
    test_random_traffic(380);
    wait_results_drained();
    write_initial_leds(3'd7);

    send_idle_pct = 76;
    recv_idle_pct = 12;
    test_random_traffic(380);
    wait_results_drained();
    write_initial_leds(3'd0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);
    test_result_backpressure();

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/kscd_pkg.sv
design/kscd_ram.sv
design/kscd_front.sv
design/kscd_back.sv
design/keyboard_scan_code_decoder.sv
bench/tb_keyboard_scan_code_decoder.sv
